@@ src/mts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the min-tracking stack
// Action and status codes, controller states and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_FILL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       fill;
		logic       load_res;
		logic [1:0] status;
	} cmd_t;

	// Occupancy flags from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic one;
		logic full;
	} stat_t;

endpackage
`default_nettype wire

@@ src/mts_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mts_req_if / mts_rsp_if: request and response channels
// Valid/ready channels carrying one stack operation and one stack answer.
// ----------------------------------------------------------------------------
interface mts_req_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_rsp_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic signed [VALUE_WIDTH-1:0] min_value;
	logic                          is_empty;
	logic [1:0]                    status;

	modport source (output valid, output top_value, output min_value, output is_empty,
		output status, input ready);
	modport sink   (input valid, input top_value, input min_value, input is_empty,
		input status, output ready);
endinterface
`default_nettype wire

@@ src/mts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl: operation controller
// Decodes accepted operations into datapath commands and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_action,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	input  wire mts_pkg::stat_t stat,
	output mts_pkg::cmd_t      cmd
);

	mts_pkg::state_t state_q, state_n;
	logic            res_valid_q;
	logic            accept;

	assign req_ready = (state_q == mts_pkg::S_IDLE) && (!res_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// A pop that uncovers a stored entry passes through S_FILL for the memory read.
	always_comb begin
		state_n = state_q;
		case (state_q)
			mts_pkg::S_IDLE: begin
				if (accept && req_action == mts_pkg::ACT_POP && !stat.empty && !stat.one) begin
					state_n = mts_pkg::S_FILL;
				end
			end
			mts_pkg::S_FILL: begin
				state_n = mts_pkg::S_IDLE;
			end
			default: begin
				state_n = mts_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = mts_pkg::ST_OK;
		case (state_q)
			mts_pkg::S_IDLE: begin
				if (accept) begin
					case (req_action)
						mts_pkg::ACT_PUSH: begin
							cmd.load_res = 1'b1;
							if (stat.full) begin
								cmd.status = mts_pkg::ST_FULL;
							end else begin
								cmd.push = 1'b1;
							end
						end
						mts_pkg::ACT_POP: begin
							if (stat.empty) begin
								cmd.load_res = 1'b1;
								cmd.status   = mts_pkg::ST_EMPTY;
							end else begin
								cmd.pop      = 1'b1;
								cmd.load_res = stat.one;
							end
						end
						default: begin
							cmd.load_res = 1'b1;
						end
					endcase
				end
			end
			mts_pkg::S_FILL: begin
				cmd.fill     = 1'b1;
				cmd.load_res = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/mts_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mts_dp: stack datapath
// Top-of-stack registers, entry memory for the entries below the top, entry
// count and the result register.
// ----------------------------------------------------------------------------
module mts_dp #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mts_pkg::cmd_t                 cmd,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output mts_pkg::stat_t                     stat,
	output logic signed [VALUE_WIDTH-1:0]      top_value,
	output logic signed [VALUE_WIDTH-1:0]      min_value,
	output logic                               is_empty,
	output logic [1:0]                         status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = 2 * VALUE_WIDTH;

	logic [DW-1:0]                 mem [STACK_DEPTH];
	logic [DW-1:0]                 rd_data_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 cnt_m1;
	logic [CW-1:0]                 cnt_m2;
	logic signed [VALUE_WIDTH-1:0] top_val_q;
	logic signed [VALUE_WIDTH-1:0] top_min_q;
	logic signed [VALUE_WIDTH-1:0] push_min;
	logic signed [VALUE_WIDTH-1:0] nxt_top;
	logic signed [VALUE_WIDTH-1:0] nxt_min;
	logic                          nxt_empty;
	logic signed [VALUE_WIDTH-1:0] res_top_q;
	logic signed [VALUE_WIDTH-1:0] res_min_q;
	logic                          res_empty_q;
	logic [1:0]                    res_status_q;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);

	assign stat.empty = (count_q == '0);
	assign stat.one   = (count_q == CW'(1));
	assign stat.full  = (count_q == CW'(STACK_DEPTH));

	// The running minimum of a new entry sees the minimum held at the top.
	assign push_min = (!stat.empty && (top_min_q < value)) ? top_min_q : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_val_q <= value;
			top_min_q <= push_min;
		end else if (cmd.fill) begin
			top_val_q <= rd_data_q[DW-1:VALUE_WIDTH];
			top_min_q <= rd_data_q[VALUE_WIDTH-1:0];
		end
	end

	// The old top moves into memory on a push; a pop reads the entry below it.
	always_ff @(posedge clk) begin
		if (cmd.push && !stat.empty) begin
			mem[cnt_m1[AW-1:0]] <= {top_val_q, top_min_q};
		end
		if (cmd.pop) begin
			rd_data_q <= mem[cnt_m2[AW-1:0]];
		end
	end

	always_comb begin
		if (cmd.fill) begin
			nxt_top   = rd_data_q[DW-1:VALUE_WIDTH];
			nxt_min   = rd_data_q[VALUE_WIDTH-1:0];
			nxt_empty = 1'b0;
		end else if (cmd.push) begin
			nxt_top   = value;
			nxt_min   = push_min;
			nxt_empty = 1'b0;
		end else if (cmd.pop) begin
			nxt_top   = top_val_q;
			nxt_min   = top_min_q;
			nxt_empty = 1'b1;
		end else begin
			nxt_top   = top_val_q;
			nxt_min   = top_min_q;
			nxt_empty = stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_top_q    <= nxt_empty ? '1 : nxt_top;
			res_min_q    <= nxt_empty ? '1 : nxt_min;
			res_empty_q  <= nxt_empty;
			res_status_q <= cmd.status;
		end
	end

	assign top_value = res_top_q;
	assign min_value = res_min_q;
	assign is_empty  = res_empty_q;
	assign status    = res_status_q;

endmodule
`default_nettype wire

@@ src/min_tracking_stack_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_core: stack of signed values that tracks its minimum
// Each request pushes, pops or queries; each answer gives the top, the
// minimum, an empty flag and a status code.
// ----------------------------------------------------------------------------
//
//   channel  role    payload
//   req      sink    action, value
//   rsp      source  top_value, min_value, is_empty, status
//
// A push, a query, a rejected operation and a pop that empties the stack
// load the result register directly. A pop that uncovers an entry held below
// the top first passes through S_FILL, as the memory read port is registered.
// In the datapath reset clears the entry count only; memory needs no clearing.
// In S_IDLE a new request is taken while the result register is free or is
// being transferred in the same cycle; a stalled response holds off requests.
//
// The top entry and its running minimum live in registers; all older entries
// sit in a single-port-write, single-port-read memory, each stored with the
// minimum of itself and everything below it. A push spills the old top into
// memory, and a pop reads the entry below back into the top registers, so the
// previous minimum returns without any search.
module min_tracking_stack_core #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	mts_pkg::cmd_t  cmd;
	mts_pkg::stat_t stat;

	// The controller sequences each operation and holds the result valid flag.
	mts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath holds the stack contents and the result register.
	mts_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (req.value),
		.stat      (stat),
		.top_value (rsp.top_value),
		.min_value (rsp.min_value),
		.is_empty  (rsp.is_empty),
		.status    (rsp.status)
	);

`ifndef NO_ASSERTIONS
	// A pop that uncovers a stored entry is always followed by the refill.
	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && !stat.one) |=> cmd.fill)
		else $error("pop of a deeper entry was not followed by a refill");

	// The result register is free while the refill loads it.
	a_fill_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !rsp.valid)
		else $error("refill while a result is still pending");

	// A full stack never takes another entry.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push issued on a full stack");

	// An accepted request that does not load its result at once loads it in
	// the following cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !cmd.load_res) |=> cmd.load_res)
		else $error("accepted request produced no result");
`endif

endmodule
`default_nettype wire

@@ tb/sv/min_tracking_stack_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core_tb: self-checking bench for the min-tracking stack
// A queue-fed driver sends push, pop and query requests with random gaps while
// a monitor stalls the response channel at random and checks every answer
// against a cycle-free model of the stack kept inside the bench.
// ----------------------------------------------------------------------------
module min_tracking_stack_core_tb;

	localparam int VW           = 32;
	localparam int DEPTH        = 64;
	localparam int RANDOM_OPS   = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 29;
	// Code three carries no meaning; the stack answers it like a query.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// One pending request. The drain flag holds the request back until every
	// earlier answer has been transferred.
	typedef struct {
		logic [1:0]    action;
		logic [VW-1:0] value;
		bit            drain;
	} stack_op_t;

	typedef struct {
		logic [VW-1:0] top;
		logic [VW-1:0] minv;
		logic          empty;
		logic [1:0]    status;
	} stack_answer_t;

	logic clk;
	logic arst_n;

	mts_req_if #(.VALUE_WIDTH(VW)) req_ch ();
	mts_rsp_if #(.VALUE_WIDTH(VW)) rsp_ch ();

	min_tracking_stack_core #(
		.STACK_DEPTH(DEPTH),
		.VALUE_WIDTH(VW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	// Requests still to be sent and answers still to be seen.
	stack_op_t     pending_ops[$];
	stack_answer_t expected_answers[$];

	// The bench's own copy of the stack. Only entries below model_depth are
	// ever read, so the arrays need no clearing.
	logic signed [VW-1:0] model_vals[DEPTH];
	logic signed [VW-1:0] model_mins[DEPTH];
	int                   model_depth;

	// Transfer counters are updated with nonblocking assignments, so every
	// block sees the values from before the current edge, whatever the order
	// in which the blocks run.
	int req_count;
	int rsp_count;
	int total_ops;
	int errors;
	int cycle_count;

	stack_answer_t want_answer;

	// Applies one request to the model and returns the answer it must give.
	function automatic stack_answer_t apply_stack_op(input logic [1:0] action,
		input logic signed [VW-1:0] v);
		stack_answer_t        ans;
		logic signed [VW-1:0] run_min;
		ans.status = mts_pkg::ST_OK;
		if (action == mts_pkg::ACT_PUSH) begin
			if (model_depth >= DEPTH) begin
				ans.status = mts_pkg::ST_FULL;
			end else begin
				run_min = v;
				if (model_depth > 0 && model_mins[model_depth-1] < v) begin
					run_min = model_mins[model_depth-1];
				end
				model_vals[model_depth] = v;
				model_mins[model_depth] = run_min;
				model_depth++;
			end
		end else if (action == mts_pkg::ACT_POP) begin
			if (model_depth == 0) begin
				ans.status = mts_pkg::ST_EMPTY;
			end else begin
				model_depth--;
			end
		end
		if (model_depth == 0) begin
			ans.top   = '1;
			ans.minv  = '1;
			ans.empty = 1'b1;
		end else begin
			ans.top   = model_vals[model_depth-1];
			ans.minv  = model_mins[model_depth-1];
			ans.empty = 1'b0;
		end
		return ans;
	endfunction

	task automatic queue_op(input logic [1:0] action, input logic [VW-1:0] value,
		input bit drain);
		stack_op_t op;
		op.action = action;
		op.value  = value;
		op.drain  = drain;
		pending_ops.push_back(op);
	endtask

	// Mixes full-range values with small ones, extremes and repeats, so that
	// ties with the running minimum and both ends of the signed range occur.
	function automatic logic [VW-1:0] pick_value(input logic [VW-1:0] last);
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1, 2, 3: begin
				return $urandom();
			end
			4, 5: begin
				return VW'($signed($urandom_range(16)) - 8);
			end
			6: begin
				case ($urandom_range(3))
					0:       return {1'b0, {(VW-1){1'b1}}};
					1:       return {1'b1, {(VW-1){1'b0}}};
					2:       return '0;
					default: return '1;
				endcase
			end
			7, 8: begin
				return last;
			end
			default: begin
				return last - VW'($urandom_range(3));
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [VW-1:0] want,
		input logic [VW-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
				$time, name, $signed(want), want, $signed(got), got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus: a short directed opening, then random segments whose push
	// bias changes from segment to segment so the stack swings between empty
	// and full.
	initial begin
		int            seg_len;
		int            push_pct;
		int            roll;
		int            made;
		logic [1:0]    act;
		logic [VW-1:0] last_val;

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = mts_pkg::ACT_QUERY;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;
		errors        = 0;
		model_depth   = 0;

		// Empty stack: query, pop and the unused code, all on nothing.
		queue_op(mts_pkg::ACT_QUERY, 32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'hFFFF_FFFF, 1'b0);
		queue_op(ACT_UNUSED,         32'h1234_5678, 1'b0);
		// Largest positive, then most negative, a value in between and a tie.
		queue_op(mts_pkg::ACT_PUSH,  32'h7FFF_FFFF, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'h8000_0000, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'h0000_0005, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'h8000_0000, 1'b0);
		queue_op(mts_pkg::ACT_QUERY, 32'hAAAA_AAAA, 1'b0);
		queue_op(ACT_UNUSED,         32'h5555_5555, 1'b0);
		// Pops bring each earlier minimum back.
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h8000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h7FFF_FFFF, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'hFFFF_FFFF, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_PUSH,  32'hFFFF_FFFE, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b1);
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b0);
		queue_op(mts_pkg::ACT_POP,   32'h0000_0000, 1'b0);

		made     = 0;
		last_val = '0;
		while (made < RANDOM_OPS) begin
			if (made == 0) begin
				// Open with a push-heavy run long enough to fill the stack.
				seg_len  = 90;
				push_pct = 95;
			end else begin
				seg_len = $urandom_range(120, 20);
				case ($urandom_range(3))
					0:       push_pct = 25;
					1:       push_pct = 50;
					2:       push_pct = 75;
					default: push_pct = 95;
				endcase
			end
			for (int j = 0; j < seg_len && made < RANDOM_OPS; j++) begin
				roll = $urandom_range(99);
				if (roll < 3) begin
					act = ACT_UNUSED;
				end else begin
					roll = $urandom_range(99);
					if (roll < push_pct) begin
						act = mts_pkg::ACT_PUSH;
					end else if (roll < push_pct + (100 - push_pct) * 3 / 4) begin
						act = mts_pkg::ACT_POP;
					end else begin
						act = mts_pkg::ACT_QUERY;
					end
				end
				if (act == mts_pkg::ACT_PUSH) begin
					last_val = pick_value(last_val);
					queue_op(act, last_val, (made % 350) == 175);
				end else begin
					queue_op(act, $urandom(), (made % 350) == 175);
				end
				made++;
			end
		end
		total_ops = pending_ops.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be sent and every answer to come back,
		// then keep the clock running so that any stray answer can show.
		while (req_count < total_ops || rsp_count < req_count) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (expected_answers.size() != 0) begin
			errors++;
			$display("%0t ns: %0d answers never arrived, expected %0d, actual 0",
				$time, expected_answers.size(), expected_answers.size());
		end
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Driver. A request is taken at an edge where valid and ready are both
	// high; the model is advanced right there so expectations stay in order.
	// A held request is never withdrawn, and valid gets one assignment per
	// edge, so back-to-back transfers keep it high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.action <= mts_pkg::ACT_QUERY;
			req_ch.value  <= '0;
			req_count     <= 0;
		end else begin
			bit taken;
			bit calm_tx;
			int in_flight;
			taken     = req_ch.valid && req_ch.ready;
			calm_tx   = (req_count >= 500) && (req_count < 800);
			in_flight = req_count + (taken ? 1 : 0) - rsp_count
				- ((rsp_ch.valid && rsp_ch.ready) ? 1 : 0);
			if (taken) begin
				expected_answers.push_back(apply_stack_op(req_ch.action, req_ch.value));
				req_count <= req_count + 1;
			end
			if (!req_ch.valid || taken) begin
				if (pending_ops.size() > 0
					&& (calm_tx || $urandom_range(99) >= IDLE_PCT)
					&& !(pending_ops[0].drain && in_flight != 0)) begin
					stack_op_t op;
					op = pending_ops.pop_front();
					req_ch.valid  <= 1'b1;
					req_ch.action <= op.action;
					req_ch.value  <= op.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each transferred answer is matched against the oldest
	// expectation; ready is dropped at random to stall the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_count    <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_count <= rsp_count + 1;
				if (expected_answers.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected answer, expected none, actual top %0d min %0d",
						$time, rsp_ch.top_value, rsp_ch.min_value);
				end else begin
					want_answer = expected_answers.pop_front();
					check_field("top_value", want_answer.top, rsp_ch.top_value);
					check_field("min_value", want_answer.minv, rsp_ch.min_value);
					check_field("is_empty", VW'(want_answer.empty), VW'(rsp_ch.is_empty));
					check_field("status", VW'(want_answer.status), VW'(rsp_ch.status));
				end
			end
			rsp_ch.ready <= ((rsp_count >= 500) && (rsp_count < 800))
				|| ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
